// ===== design/cpcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Completed-packet credit reporter package
// Shared widths, codes, request/response payload types and cell control.
// ----------------------------------------------------------------------------
package cpcr_pkg;

    // Field widths.
    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned HANDLE_W = 12;
    localparam int unsigned CNT_W    = 12;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned TMR_W    = 16;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Saturation limit of every counter.
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Most entries one flush may report.
    localparam int unsigned RES_MAX = 8;
    localparam int unsigned NEMIT_W = 4;

    // Event codes.
    localparam logic [FUNC_W-1:0] FUNC_FREED  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BROKEN = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_TICKS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_ON_DISC  = 2'd3;

    // One event request.
    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [HANDLE_W-1:0] link_handle;
    } t_req;

    // One result.
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] report_handle;
        logic [CNT_W-1:0]    report_count;
        logic                last;
    } t_rsp;

    // Control of one counter cell.
    typedef struct packed {
        logic shift;
        logic inc;
    } t_cell_ctrl;

endpackage

// ===== design/cpcr_if.sv =====
// ----------------------------------------------------------------------------
// Completed-packet credit reporter channels
// Valid/ready channels for event requests and for results.
// ----------------------------------------------------------------------------
interface cpcr_req_if;
    import cpcr_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cpcr_rsp_if;
    import cpcr_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/cpcr_cell.sv =====
// ----------------------------------------------------------------------------
// Completed-packet counter cell
// Holds one connection's count; either takes its neighbor's count during a
// scan or counts up (saturating) on a freed buffer.
// ----------------------------------------------------------------------------
module cpcr_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cpcr_pkg::t_cell_ctrl        i_ctrl,
    input  logic [cpcr_pkg::CNT_W-1:0]  i_shift_count,
    output logic [cpcr_pkg::CNT_W-1:0]  o_count
);
    import cpcr_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // Shift from the neighbor, or count up one freed buffer.
    always_comb begin
        n_count = r_count;
        if (i_ctrl.shift) begin
            n_count = i_shift_count;
        end else if (i_ctrl.inc && (r_count != CNT_MAX)) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

// ===== design/completed_packet_credit_reporter.sv =====
// ----------------------------------------------------------------------------
// Completed-packet credit reporter
// Host flow-control bookkeeping: per-connection completed-packet counts,
// a global count, and threshold, interval-timer and disconnect flushes.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one event per request: a freed buffer with its connection
//   handle, a timer tick, or a broken connection. o_rsp carries the results;
//   every request gives one or more, and the final one has last set.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the block is idle.
// Flushes:
//   An event without a flush leaves its result in the output register in
//   the cycle after it is accepted. An event that flushes starts a scan:
//   the counters sit in a ring of MAX_CONN cells that rotates one place per
//   cycle, while the output can take a result, past the head cell, which is
//   where each count is reported and cleared. A new request is taken once
//   the scan is done.
// Reset:
//   All counts, the global count and the timer are cleared; the registers
//   take their defaults (12 buffers, threshold 2, 1000 ticks, no flush on
//   disconnect). No clearing pass is needed.
// Stalls:
//   When o_rsp is not taken, the output register holds its result and the
//   scan ring stops until the register frees up; no request is accepted.
// ----------------------------------------------------------------------------
module completed_packet_credit_reporter #(
    parameter int unsigned MAX_CONN = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cpcr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cpcr_pkg::CFG_W-1:0]      i_cfg_data,
    cpcr_req_if.sink                        i_req,
    cpcr_rsp_if.source                      o_rsp
);
    import cpcr_pkg::*;

    localparam int unsigned IDX_W = (MAX_CONN > 1) ? $clog2(MAX_CONN) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_CONN - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    // Configuration registers.
    logic [CNT_W-1:0] r_buffer_count;
    logic [CNT_W-1:0] r_free_threshold;
    logic [TMR_W-1:0] r_interval_ticks;
    logic             r_flush_on_disc;

    // Control state.
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_global, n_global;
    logic               r_armed, n_armed;
    logic [TMR_W-1:0]   r_remain, n_remain;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [NEMIT_W-1:0] r_nemit, n_nemit;
    logic               r_out_valid, n_out_valid;
    t_rsp               r_out, n_out;

    // Cell ring.
    logic [CNT_W-1:0] w_count [MAX_CONN];
    logic [CNT_W-1:0] w_shift_in [MAX_CONN];
    t_cell_ctrl       w_ctrl [MAX_CONN];

    logic             w_out_free;
    logic             w_req_fire;
    logic             w_inc_hit;
    logic             w_shift;
    logic             w_emit_entry;
    logic             w_rest_nz;
    logic [CNT_W-1:0] w_wrap;

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_req_fire = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data = r_out;

    // A freed buffer counts up the cell its handle names.
    assign w_inc_hit = w_req_fire && (i_req.data.func == FUNC_FREED)
        && (i_req.data.link_handle < HANDLE_W'(MAX_CONN));

    // The ring rotates one place per scan step, whenever the output can take a result.
    assign w_shift = (r_state == ST_SCAN) && w_out_free;

    // The head cell is reported if nonzero and the entry limit is not reached.
    assign w_emit_entry = (w_count[0] != '0) && (r_nemit != NEMIT_W'(RES_MAX));
    assign w_wrap = w_emit_entry ? '0 : w_count[0];

    // Any nonzero count still ahead of the head among unscanned handles.
    always_comb begin
        w_rest_nz = 1'b0;
        for (int p = 1; p < MAX_CONN; p++) begin
            if ((w_count[p] != '0)
                && (({1'b0, r_idx} + (IDX_W+1)'(p)) < (IDX_W+1)'(MAX_CONN))) begin
                w_rest_nz = 1'b1;
            end
        end
    end

    // Cell ring wiring.
    for (genvar gi = 0; gi < MAX_CONN; gi++) begin : g_cell
        if (gi == MAX_CONN - 1) begin : g_tail
            assign w_shift_in[gi] = w_wrap;
        end else begin : g_mid
            assign w_shift_in[gi] = w_count[gi+1];
        end

        // Shift in the upper bit, count enable in the lower bit.
        assign w_ctrl[gi] = {w_shift, w_inc_hit
            && (i_req.data.link_handle[IDX_W-1:0] == IDX_W'(gi))};

        cpcr_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl[gi]),
            .i_shift_count (w_shift_in[gi]),
            .o_count       (w_count[gi])
        );
    end

    // Event handling and scan sequencing.
    always_comb begin
        logic [CNT_W:0] v_g;
        logic           v_flush;

        n_state = r_state;
        n_global = r_global;
        n_armed = r_armed;
        n_remain = r_remain;
        n_idx = r_idx;
        n_nemit = r_nemit;
        n_out = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        v_g = {1'b0, r_global} + (CNT_W+1)'(1);
        v_flush = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_req_fire) begin
                    n_out.kind = KIND_NONE;
                    n_out.report_handle = '0;
                    n_out.report_count = '0;
                    n_out.last = 1'b1;
                    case (i_req.data.func)
                        FUNC_FREED: begin
                            if (w_inc_hit) begin
                                n_global = v_g[CNT_W] ? CNT_MAX : v_g[CNT_W-1:0];
                                if (v_g > {1'b0, r_buffer_count}) begin
                                    n_out.kind = KIND_ERROR;
                                end else if (({1'b0, r_buffer_count} - v_g)
                                             <= {1'b0, r_free_threshold}) begin
                                    v_flush = 1'b1;
                                    n_global = '0;
                                    n_armed = 1'b0;
                                end else if (v_g == (CNT_W+1)'(1)) begin
                                    n_armed = 1'b1;
                                    n_remain = r_interval_ticks;
                                end
                            end
                        end
                        FUNC_TICK: begin
                            if (r_armed) begin
                                if (r_remain <= TMR_W'(1)) begin
                                    n_armed = 1'b0;
                                    n_remain = '0;
                                    if (r_global != '0) begin
                                        v_flush = 1'b1;
                                        n_global = '0;
                                    end
                                end else begin
                                    n_remain = r_remain - TMR_W'(1);
                                end
                            end
                        end
                        FUNC_BROKEN: begin
                            v_flush = r_flush_on_disc;
                        end
                        default: begin
                        end
                    endcase

                    if (v_flush) begin
                        n_state = ST_SCAN;
                        n_idx = '0;
                        n_nemit = '0;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (w_out_free) begin
                    if (w_emit_entry) begin
                        n_out.kind = KIND_ENTRY;
                        n_out.report_handle = HANDLE_W'(r_idx);
                        n_out.report_count = w_count[0];
                        n_out.last = (r_nemit == NEMIT_W'(RES_MAX - 1)) || !w_rest_nz;
                        n_out_valid = 1'b1;
                        n_nemit = r_nemit + NEMIT_W'(1);
                    end else if ((r_idx == IDX_LAST) && (r_nemit == '0)) begin
                        n_out.kind = KIND_NONE;
                        n_out.report_handle = '0;
                        n_out.report_count = '0;
                        n_out.last = 1'b1;
                        n_out_valid = 1'b1;
                    end
                    if (r_idx == IDX_LAST) begin
                        n_state = ST_IDLE;
                        n_idx = '0;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_count <= CNT_W'(12);
            r_free_threshold <= CNT_W'(2);
            r_interval_ticks <= TMR_W'(1000);
            r_flush_on_disc <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BUFFER_COUNT:   r_buffer_count <= i_cfg_data[CNT_W-1:0];
                CFG_FREE_THRESHOLD: r_free_threshold <= i_cfg_data[CNT_W-1:0];
                CFG_INTERVAL_TICKS: r_interval_ticks <= i_cfg_data[TMR_W-1:0];
                CFG_FLUSH_ON_DISC:  r_flush_on_disc <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_global <= '0;
            r_armed <= 1'b0;
            r_remain <= '0;
            r_idx <= '0;
            r_nemit <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_global <= n_global;
            r_armed <= n_armed;
            r_remain <= n_remain;
            r_idx <= n_idx;
            r_nemit <= n_nemit;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef SYNTH
    // A flush never reports more entries than the limit.
    a_nemit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nemit <= NEMIT_W'(RES_MAX))
        else $error("entry count above limit");

    // The last scan step always returns to idle.
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) && (r_idx == IDX_LAST) && w_out_free
        |=> (r_state == ST_IDLE))
        else $error("scan did not return to idle");

    // An accepted request either starts a scan or leaves its result.
    a_req_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_fire |=> (r_state == ST_SCAN) || (r_out_valid && r_out.last))
        else $error("request left no result");

    // A scan always starts at the lowest handle with no entries reported.
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) ##1 (r_state == ST_SCAN) |-> (r_idx == '0) && (r_nemit == '0))
        else $error("scan started in a bad state");
`endif

endmodule

// ===== tb/sv/cpcr_credit_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Completed-packet credit reporter checker
// Watches the register port and both channels, keeps its own copy of the
// per-connection credits, the global count and the interval timer, and
// compares every result with the oldest report still due.
// ----------------------------------------------------------------------------
module cpcr_credit_check #(
    parameter int unsigned MAX_CONN = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cpcr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cpcr_pkg::CFG_W-1:0]     i_cfg_data,
    cpcr_req_if                            i_req,
    cpcr_rsp_if                            i_rsp,
    output int                             o_pending,
    output int                             o_fail_count
);
    import cpcr_pkg::*;

    // Credit state of the block as this checker sees it.
    logic [CNT_W-1:0] conn_credits [MAX_CONN];
    logic [CNT_W-1:0] total_credits;
    logic             tick_armed;
    logic [TMR_W-1:0] ticks_left;

    // Register copies.
    logic [CNT_W-1:0] buffers_offered;
    logic [CNT_W-1:0] flush_floor;
    logic [TMR_W-1:0] interval_len;
    logic             disc_flush;

    // Results owed by accepted requests, oldest first.
    t_rsp             due_reports[$];
    int               mismatches;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] mismatch: %s got %0d, want %0d", $time, what, got, want);
    endtask

    // Queues one result; the last flag is set once the whole request is worked out.
    function automatic void owe(input logic [KIND_W-1:0] kind, input int unsigned handle,
                                input logic [CNT_W-1:0] count);
        t_rsp r;
        r.kind          = kind;
        r.report_handle = HANDLE_W'(handle);
        r.report_count  = count;
        r.last          = 1'b0;
        due_reports.push_back(r);
    endfunction

    // Reports and clears the nonzero connection counts in ascending handle order, up to RES_MAX of them.
    function automatic int flush_credits();
        int n;
        n = 0;
        for (int c = 0; c < MAX_CONN && n < RES_MAX; c++) begin
            if (conn_credits[c] != '0) begin
                owe(KIND_ENTRY, c, conn_credits[c]);
                conn_credits[c] = '0;
                n++;
            end
        end
        return n;
    endfunction

    // Applies one event request to the credit state and queues what it owes.
    function automatic void tally_event(input t_req ev);
        logic [CNT_W:0] sum;
        int             n;
        int             h;
        t_rsp           tail;
        n = 0;
        h = int'(ev.link_handle);
        case (ev.func)
            FUNC_FREED: begin
                if (h < MAX_CONN) begin
                    sum = {1'b0, total_credits} + 1'b1;
                    if (conn_credits[h] != CNT_MAX) begin
                        conn_credits[h] = conn_credits[h] + 1'b1;
                    end
                    total_credits = (sum > CNT_MAX) ? CNT_MAX : sum[CNT_W-1:0];
                    if (sum > buffers_offered) begin
                        // More credits than buffers: the controller misbehaved.
                        owe(KIND_ERROR, 0, '0);
                        n = 1;
                    end else if (({1'b0, buffers_offered} - sum) <= flush_floor) begin
                        n = flush_credits();
                        total_credits = '0;
                        tick_armed = 1'b0;
                    end else if (sum == 1) begin
                        tick_armed = 1'b1;
                        ticks_left = interval_len;
                    end
                end
            end
            FUNC_TICK: begin
                if (tick_armed) begin
                    if (ticks_left <= 1) begin
                        tick_armed = 1'b0;
                        ticks_left = '0;
                        if (total_credits != '0) begin
                            n = flush_credits();
                            total_credits = '0;
                        end
                    end else begin
                        ticks_left = ticks_left - 1'b1;
                    end
                end
            end
            FUNC_BROKEN: begin
                // The global count is kept and the timer left alone.
                if (disc_flush) begin
                    n = flush_credits();
                end
            end
            default: begin
            end
        endcase
        if (n == 0) begin
            owe(KIND_NONE, 0, '0);
        end
        tail = due_reports.pop_back();
        tail.last = 1'b1;
        due_reports.push_back(tail);
    endfunction

    // Compares one accepted result with the oldest report due.
    task automatic check_result(input t_rsp got);
        t_rsp want;
        if (due_reports.size() == 0) begin
            report_mismatch("result with nothing due, kind", got.kind, -1);
            return;
        end
        want = due_reports.pop_front();
        if (got.kind !== want.kind) begin
            report_mismatch("kind", got.kind, want.kind);
        end
        if (got.report_handle !== want.report_handle) begin
            report_mismatch("report_handle", got.report_handle, want.report_handle);
        end
        if (got.report_count !== want.report_count) begin
            report_mismatch("report_count", got.report_count, want.report_count);
        end
        if (got.last !== want.last) begin
            report_mismatch("last", got.last, want.last);
        end
    endtask

    // Register writes, then results, then new requests of this edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < MAX_CONN; c++) begin
                conn_credits[c] = '0;
            end
            total_credits   = '0;
            tick_armed      = 1'b0;
            ticks_left      = '0;
            buffers_offered = CNT_W'(12);
            flush_floor     = CNT_W'(2);
            interval_len    = TMR_W'(1000);
            disc_flush      = 1'b0;
            due_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BUFFER_COUNT:   buffers_offered = i_cfg_data[CNT_W-1:0];
                    CFG_FREE_THRESHOLD: flush_floor     = i_cfg_data[CNT_W-1:0];
                    CFG_INTERVAL_TICKS: interval_len    = i_cfg_data[TMR_W-1:0];
                    CFG_FLUSH_ON_DISC:  disc_flush      = i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_rsp.valid && i_rsp.ready) begin
                check_result(i_rsp.data);
            end
            if (i_req.valid && i_req.ready) begin
                tally_event(i_req.data);
            end
        end
        o_pending <= due_reports.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Completed-packet credit reporter testbench
// Drives event requests and register writes into the reporter: a directed
// walk through every event and flush path, a run at extreme register settings
// and random traffic under several register settings, with idle cycles on both
// channels. The credit checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import cpcr_pkg::*;

    localparam int unsigned MAX_CONN = 8;

    // The function code the block leaves unused.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Settle pause that covers a flush scan and the result register.
    localparam int SETTLE_CYCLES = MAX_CONN + 4;

    // Cycles without any accepted request or result before the run is abandoned.
    // The longest correct quiet stretch is a settle pause plus a short stall run.
    localparam int STALL_LIMIT = 1000;

    // Counted random requests per register setting.
    localparam int SEGMENT_LEN = 26;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    int                   tx_idle_pct;
    int                   rx_idle_pct;
    int                   pending;
    int                   fail_count;
    int                   quiet_cycles;

    cpcr_req_if req_ch ();
    cpcr_rsp_if rsp_ch ();

    completed_packet_credit_reporter #(
        .MAX_CONN (MAX_CONN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    cpcr_credit_check #(
        .MAX_CONN (MAX_CONN)
    ) u_credit_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result receiver: stalls at random at the current rate.
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog on handshake progress.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("FAIL completed_packet_credit_reporter");
        $finish;
    end

    // Offers one event request, with random idle cycles ahead of it.
    task automatic send_event(input logic [FUNC_W-1:0] func,
                              input logic [HANDLE_W-1:0] handle);
        t_req ev;
        ev.func        = func;
        ev.link_handle = handle;
        while ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= ev;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
    endtask

    // Holds the sender until every result due has come and the block is idle.
    task automatic wait_quiet();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all four registers while the block is idle.
    task automatic program_regs(input int unsigned buffers, input int unsigned floor_val,
                                input int unsigned interval, input int unsigned disc);
        wait_quiet();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_BUFFER_COUNT;
        cfg_data <= CFG_W'(buffers);
        @(posedge i_clk);
        cfg_idx  <= CFG_FREE_THRESHOLD;
        cfg_data <= CFG_W'(floor_val);
        @(posedge i_clk);
        cfg_idx  <= CFG_INTERVAL_TICKS;
        cfg_data <= CFG_W'(interval);
        @(posedge i_clk);
        cfg_idx  <= CFG_FLUSH_ON_DISC;
        cfg_data <= CFG_W'(disc);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Random register setting, mostly small pools and short intervals so that
    // every kind of flush happens often; extremes now and then.
    task automatic program_random();
        int unsigned buffers;
        int unsigned floor_val;
        int unsigned interval;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10) begin
            buffers = 1;
        end else if (roll < 20) begin
            buffers = 4095;
        end else begin
            buffers = $urandom_range(24, 2);
        end
        roll = $urandom_range(99);
        if (roll < 10) begin
            floor_val = 0;
        end else if (roll < 20) begin
            floor_val = 4095;
        end else begin
            floor_val = $urandom_range(buffers, 0);
        end
        roll = $urandom_range(99);
        if (roll < 10) begin
            interval = 1;
        end else if (roll < 15) begin
            interval = 65535;
        end else begin
            interval = $urandom_range(6, 1);
        end
        program_regs(buffers, floor_val, interval, $urandom_range(1));
    endtask

    // One random request; counted is low for requests the block ignores.
    task automatic send_random(output bit counted);
        logic [FUNC_W-1:0]   func;
        logic [HANDLE_W-1:0] handle;
        int unsigned         roll;
        roll   = $urandom_range(99);
        handle = HANDLE_W'($urandom);
        if (roll < 55) begin
            func   = FUNC_FREED;
            handle = HANDLE_W'($urandom_range(MAX_CONN - 1));
        end else if (roll < 60) begin
            func = FUNC_FREED;
        end else if (roll < 85) begin
            func = FUNC_TICK;
        end else if (roll < 95) begin
            func = FUNC_BROKEN;
        end else begin
            func = FUNC_UNUSED;
        end
        counted = !(func == FUNC_UNUSED || (func == FUNC_FREED && handle >= MAX_CONN));
        send_event(func, handle);
    endtask

    // Random traffic with a fresh register setting every segment.
    task automatic run_random(input int target);
        int done;
        int seg;
        bit counted;
        done = 0;
        seg  = 0;
        program_random();
        while (done < target) begin
            send_random(counted);
            if (counted) begin
                done++;
                seg++;
            end
            if (seg == SEGMENT_LEN) begin
                program_random();
                seg = 0;
            end else if ($urandom_range(99) < 3) begin
                wait_quiet();
            end
        end
    endtask

    // Walks each event type and each flush path once.
    task automatic run_directed();
        // Reset settings: nothing armed, broken connections do not flush.
        send_event(FUNC_TICK, 12'd0);
        send_event(FUNC_UNUSED, 12'hFFF);
        send_event(FUNC_FREED, 12'd8);
        send_event(FUNC_FREED, 12'hFFF);
        send_event(FUNC_BROKEN, 12'd0);

        // Zero interval: the timer expires on the next tick.
        program_regs(12, 2, 0, 1);
        send_event(FUNC_FREED, 12'd0);
        send_event(FUNC_TICK, 12'd0);
        send_event(FUNC_TICK, 12'd0);

        // Every connection pending, then a disconnect reports all of them.
        for (int c = 1; c <= MAX_CONN; c++) begin
            send_event(FUNC_FREED, HANDLE_W'(c % MAX_CONN));
        end
        send_event(FUNC_BROKEN, 12'hFFF);

        // The global count survived the disconnect; a smaller pool overflows.
        program_regs(4, 4095, 1, 0);
        send_event(FUNC_FREED, 12'd2);
        send_event(FUNC_BROKEN, 12'd0);

        // Back to twelve buffers: free count reaches the threshold exactly.
        program_regs(12, 2, 65535, 1);
        send_event(FUNC_FREED, 12'd3);
        send_event(FUNC_FREED, 12'd6);
        send_event(FUNC_TICK, 12'd0);
        send_event(FUNC_BROKEN, 12'd0);
        send_event(FUNC_FREED, 12'd6);
    endtask

    // Registers at their extremes: largest pool and threshold, then a one-buffer pool.
    task automatic run_extremes();
        // Threshold at its top: the next free flushes whatever is pending.
        program_regs(4095, 4095, 2, 0);
        send_event(FUNC_FREED, 12'd0);

        // A few credits pending with the timer armed.
        program_regs(4095, 0, 2, 0);
        repeat (3) send_event(FUNC_FREED, 12'd3);

        // A one-buffer pool turns further frees into controller errors.
        program_regs(1, 0, 2, 0);
        repeat (3) send_event(FUNC_FREED, 12'd3);

        program_regs(4095, 0, 2, 1);
        send_event(FUNC_BROKEN, 12'd0);
        send_event(FUNC_FREED, 12'd4);
        repeat (2) send_event(FUNC_TICK, 12'd0);
    endtask

    // Reset, stimulus phases and verdict.
    initial begin
        i_rst_n      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= CFG_BUFFER_COUNT;
        cfg_data     <= '0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        tx_idle_pct  = 22;
        rx_idle_pct  = 54;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles lightly, receiver stalls heavily.
        run_directed();
        run_random(85);

        // The other way round.
        tx_idle_pct = 54;
        rx_idle_pct = 22;
        run_random(85);

        // Neither side idles.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_extremes();
        run_random(80);

        wait_quiet();
        if (fail_count == 0) begin
            $display("PASS completed_packet_credit_reporter");
        end else begin
            $display("FAIL completed_packet_credit_reporter");
        end
        $finish;
    end

endmodule
